/* sv/hrhs_pkg.sv */
// ----------------------------------------------------------------------------
// hrhs_pkg
// Types and constants shared by the HTTP reply header stripper modules.
// ----------------------------------------------------------------------------
`default_nettype none

package hrhs_pkg;

  // Depth of the result queue; the input side needs room for two results
  localparam int unsigned OutDepth = 4;
  localparam int unsigned OutPtrW  = $clog2(OutDepth);
  localparam int unsigned OutCntW  = $clog2(OutDepth + 1);

  // Parse position inside the reply
  typedef enum logic [2:0] {
    PH_PREFIX   = 3'd0,
    PH_VER_NONE = 3'd1,
    PH_VER      = 3'd2,
    PH_BLANKS   = 3'd3,
    PH_STATUS   = 3'd4,
    PH_REST     = 3'd5,
    PH_HEADERS  = 3'd6,
    PH_AFTER    = 3'd7
  } phase_e;

  // Verdict codes
  typedef enum logic [2:0] {
    V_OK        = 3'd0,
    V_REDIRECT  = 3'd1,
    V_OTHER     = 3'd2,
    V_MALFORMED = 3'd3,
    V_NO_END    = 3'd4
  } verdict_e;

  // Result kinds
  localparam logic KIND_BODY    = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // One result item
  typedef struct packed {
    logic        out_kind;
    logic [7:0]  body_byte;
    verdict_e    verdict;
    logic [15:0] status_value;
    logic        is_last;
  } result_t;

  // Results produced by one accepted byte, in order: first, then second
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

`default_nettype wire

/* sv/hrhs_if.sv */
// ----------------------------------------------------------------------------
// hrhs_in_if / hrhs_out_if
// Valid/ready channels for received bytes and for result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface hrhs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       end_of_reply;

  modport source (output valid, output rx_byte, output end_of_reply, input ready);
  modport sink   (input valid, input rx_byte, input end_of_reply, output ready);
endinterface

interface hrhs_out_if;
  logic        valid;
  logic        ready;
  logic        out_kind;
  logic [7:0]  body_byte;
  logic [2:0]  verdict;
  logic [15:0] status_value;
  logic        is_last;

  modport source (output valid, output out_kind, output body_byte, output verdict,
                  output status_value, output is_last, input ready);
  modport sink   (input valid, input out_kind, input body_byte, input verdict,
                  input status_value, input is_last, output ready);
endinterface

`default_nettype wire

/* sv/hrhs_parser.sv */
// ----------------------------------------------------------------------------
// hrhs_parser
// Per-byte parse of status line and headers; yields up to two results a byte.
// ----------------------------------------------------------------------------
`default_nettype none

module hrhs_parser (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          accept_i,
  input  wire logic [7:0]    rx_byte_i,
  input  wire logic          end_of_reply_i,
  output hrhs_pkg::push_t    push_o
);
  import hrhs_pkg::*;

  localparam logic [7:0] ChCr  = 8'h0D;
  localparam logic [7:0] ChLf  = 8'h0A;
  localparam logic [7:0] ChDot = 8'h2E;

  typedef struct packed {
    phase_e      phase;
    logic [2:0]  prefix_index;
    logic        dot_seen;
    logic [15:0] status_accum;
    verdict_e    verdict;
    logic        prev_was_cr;
    logic        line_is_empty;
  } state_t;

  function automatic state_t reset_state();
    state_t r;
    r.phase         = PH_PREFIX;
    r.prefix_index  = 3'd0;
    r.dot_seen      = 1'b0;
    r.status_accum  = 16'd0;
    r.verdict       = V_NO_END;
    r.prev_was_cr   = 1'b0;
    r.line_is_empty = 1'b1;
    return r;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09);
  endfunction

  // Characters of "HTTP/"
  function automatic logic [7:0] tag_char(logic [2:0] idx);
    logic [7:0] ch;
    unique case (idx)
      3'd0:    ch = 8'h48;
      3'd1:    ch = 8'h54;
      3'd2:    ch = 8'h54;
      3'd3:    ch = 8'h50;
      default: ch = 8'h2F;
    endcase
    return ch;
  endfunction

  // One ordinary byte of the status line
  function automatic state_t parse_byte(state_t s, logic [7:0] c);
    state_t      r;
    logic [19:0] prod;
    r    = s;
    prod = {1'b0, s.status_accum, 3'b000} + {3'b000, s.status_accum, 1'b0}
         + {16'd0, c[3:0]};
    case (s.phase)
      PH_PREFIX: begin
        if (c == tag_char(s.prefix_index)) begin
          r.prefix_index = s.prefix_index + 3'd1;
          if (s.prefix_index == 3'd4) r.phase = PH_VER_NONE;
        end else begin
          r.phase   = PH_REST;
          r.verdict = V_MALFORMED;
        end
      end
      PH_VER_NONE: begin
        if (is_digit(c)) begin
          r.phase = PH_VER;
        end else if (c == ChDot && !s.dot_seen) begin
          r.dot_seen = 1'b1;
        end else if (!(is_blank(c) && !s.dot_seen)) begin
          r.phase   = PH_REST;
          r.verdict = V_MALFORMED;
        end
      end
      PH_VER: begin
        if (is_digit(c)) begin
          r.phase = PH_VER;
        end else if (c == ChDot && !s.dot_seen) begin
          r.dot_seen = 1'b1;
        end else if (is_blank(c)) begin
          r.phase = PH_BLANKS;
        end else begin
          r.phase   = PH_REST;
          r.verdict = V_MALFORMED;
        end
      end
      PH_BLANKS: begin
        if (is_digit(c)) begin
          r.status_accum = {12'd0, c[3:0]};
          r.phase        = PH_STATUS;
        end else if (!is_blank(c)) begin
          r.phase   = PH_REST;
          r.verdict = V_MALFORMED;
        end
      end
      PH_STATUS: begin
        if (is_digit(c)) begin
          r.status_accum = (prod[19:16] != 4'd0) ? 16'hFFFF : prod[15:0];
        end else begin
          r.phase = PH_REST;
        end
      end
      default: r = s;
    endcase
    return r;
  endfunction

  // CRLF closing the status line
  function automatic state_t line_end(state_t s);
    state_t r;
    r = s;
    if (!(s.phase == PH_STATUS || (s.phase == PH_REST && s.verdict != V_MALFORMED))) begin
      r.phase   = PH_AFTER;
      r.verdict = V_MALFORMED;
    end else if (s.status_accum == 16'd200) begin
      r.phase         = PH_HEADERS;
      r.line_is_empty = 1'b1;
      r.verdict       = V_NO_END;
    end else begin
      r.phase   = PH_AFTER;
      r.verdict = (s.status_accum == 16'd301 || s.status_accum == 16'd302) ?
                  V_REDIRECT : V_OTHER;
    end
    return r;
  endfunction

  state_t  state_q, state_d, step_s;
  result_t body_item, verdict_item;
  logic    body_en;

  // Next state and results for the byte at the input
  always_comb begin
    step_s  = state_q;
    body_en = 1'b0;
    if (state_q.phase <= PH_REST) begin
      if (state_q.prev_was_cr && rx_byte_i == ChLf) begin
        step_s.prev_was_cr = 1'b0;
        step_s = line_end(step_s);
      end else begin
        if (state_q.prev_was_cr) step_s = parse_byte(step_s, ChCr);
        if (rx_byte_i == ChCr) begin
          step_s.prev_was_cr = 1'b1;
        end else begin
          step_s.prev_was_cr = 1'b0;
          step_s = parse_byte(step_s, rx_byte_i);
        end
      end
    end else if (state_q.phase == PH_HEADERS) begin
      if (state_q.prev_was_cr && rx_byte_i == ChLf) begin
        step_s.prev_was_cr = 1'b0;
        if (state_q.line_is_empty) begin
          step_s.phase   = PH_AFTER;
          step_s.verdict = V_OK;
        end else begin
          step_s.line_is_empty = 1'b1;
        end
      end else if (rx_byte_i == ChCr) begin
        if (state_q.prev_was_cr) step_s.line_is_empty = 1'b0;
        step_s.prev_was_cr = 1'b1;
      end else begin
        step_s.prev_was_cr   = 1'b0;
        step_s.line_is_empty = 1'b0;
      end
    end else begin
      body_en = (state_q.verdict == V_OK);
    end

    // body item
    body_item.out_kind     = KIND_BODY;
    body_item.body_byte    = rx_byte_i;
    body_item.verdict      = V_OK;
    body_item.status_value = 16'd0;
    body_item.is_last      = 1'b0;

    // verdict item, taken from the state after this byte
    verdict_item.out_kind     = KIND_VERDICT;
    verdict_item.body_byte    = 8'd0;
    verdict_item.verdict      = (step_s.phase == PH_AFTER) ? step_s.verdict : V_NO_END;
    verdict_item.status_value =
      (step_s.phase == PH_HEADERS ||
       (step_s.phase == PH_AFTER && step_s.verdict <= V_OTHER)) ?
      step_s.status_accum : 16'd0;
    verdict_item.is_last      = 1'b1;

    state_d = end_of_reply_i ? reset_state() : step_s;

    // pack results in order
    push_o.count  = accept_i ? ({1'b0, body_en} + {1'b0, end_of_reply_i}) : 2'd0;
    push_o.first  = body_en ? body_item : verdict_item;
    push_o.second = verdict_item;
  end

  // Parse state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= reset_state();
    end else if (accept_i) begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

/* sv/hrhs_out_queue.sv */
// ----------------------------------------------------------------------------
// hrhs_out_queue
// Small result queue that takes up to two items a cycle and sends one while the sink is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module hrhs_out_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire hrhs_pkg::push_t push_i,
  output logic                 room_o,
  hrhs_out_if.source           out_o
);
  import hrhs_pkg::*;

  result_t              mem_q [OutDepth];
  logic [OutPtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [OutCntW-1:0]   cnt_q;
  logic                 pop;
  logic [OutPtrW-1:0]   wr_next;
  result_t              head;

  assign wr_next = wr_ptr_q + OutPtrW'(1);
  assign pop     = out_o.valid && out_o.ready;
  assign room_o  = cnt_q <= OutCntW'(OutDepth - 2);
  assign head    = mem_q[rd_ptr_q];

  // Output side
  assign out_o.valid        = cnt_q != '0;
  assign out_o.out_kind     = head.out_kind;
  assign out_o.body_byte    = head.body_byte;
  assign out_o.verdict      = head.verdict;
  assign out_o.status_value = head.status_value;
  assign out_o.is_last      = head.is_last;

  // Storage writes
  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) mem_q[wr_ptr_q] <= push_i.first;
    if (push_i.count == 2'd2) mem_q[wr_next]  <= push_i.second;
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + OutPtrW'(push_i.count);
      if (pop) rd_ptr_q <= rd_ptr_q + OutPtrW'(1);
      cnt_q <= cnt_q + OutCntW'(push_i.count) - OutCntW'(pop);
    end
  end

endmodule

`default_nettype wire

/* sv/http_reply_header_stripper.sv */
// Each result is written into the result queue when its byte transfers.
// Up to one byte per cycle while the result queue has room; a byte that yields
// body and verdict gives two results, sent in turn by the single-read queue.
// Input ready drops when the four-entry result queue has no room for two.
// Reset (async, active low) puts the parser at the start of a reply and
// empties the result queue; each final byte also returns the parser there.
// ----------------------------------------------------------------------------
// http_reply_header_stripper
// Checks an HTTP status line, skips headers and passes the body of 200 replies.
// ----------------------------------------------------------------------------
`default_nettype none

module http_reply_header_stripper (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  hrhs_in_if.sink     in_i,
  hrhs_out_if.source  out_o
);
  import hrhs_pkg::*;

  logic  accept;
  logic  room;
  push_t push;

  assign in_i.ready = room;
  assign accept     = in_i.valid && room;

  hrhs_parser u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .rx_byte_i      (in_i.rx_byte),
    .end_of_reply_i (in_i.end_of_reply),
    .push_o         (push)
  );

  hrhs_out_queue u_out_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .room_o (room),
    .out_o  (out_o)
  );

endmodule

`default_nettype wire

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the HTTP reply header stripper. Replies are fed
// byte by byte over the input channel while a shadow parser predicts the
// body bytes and the closing verdict of every reply; a checker process
// compares each result transfer against the oldest prediction.
// ----------------------------------------------------------------------------

module tb_top;
  import hrhs_pkg::*;

  // Character codes used by the shadow parser
  localparam logic [7:0]  CH_CR   = 8'h0D;
  localparam logic [7:0]  CH_LF   = 8'h0A;
  localparam logic [7:0]  CH_SP   = 8'h20;
  localparam logic [7:0]  CH_TAB  = 8'h09;
  localparam logic [7:0]  CH_DOT  = 8'h2E;
  localparam logic [7:0]  CH_ZERO = 8'h30;
  localparam logic [7:0]  CH_NINE = 8'h39;
  localparam logic [39:0] HTTP_TAG = "HTTP/";
  localparam int unsigned TAG_LEN  = 5;
  localparam int unsigned STATUS_MAX = 65535;

  logic clk_i;
  logic rst_ni;

  hrhs_in_if  in_if ();
  hrhs_out_if out_if ();

  http_reply_header_stripper u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Shadow parser state
  phase_e      sh_phase;
  logic [2:0]  sh_tag_idx;
  logic        sh_dot;
  logic [15:0] sh_status;
  verdict_e    sh_verdict;
  logic        sh_cr;
  logic        sh_line_empty;

  result_t     pending_results[$];
  logic [7:0]  reply_buf[$];

  bit          src_idle_en;
  bit          snk_idle_en;
  int unsigned errors;
  int unsigned bytes_sent;
  int unsigned replies_sent;
  int unsigned results_seen;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Shadow parser
  // ---------------------------------------------------------------------------
  function automatic bit is_digit(logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return (c == CH_SP) || (c == CH_TAB);
  endfunction

  task automatic parser_clear();
    sh_phase      = PH_PREFIX;
    sh_tag_idx    = '0;
    sh_dot        = 1'b0;
    sh_status     = '0;
    sh_verdict    = V_NO_END;
    sh_cr         = 1'b0;
    sh_line_empty = 1'b1;
  endtask

  task automatic mark_malformed();
    sh_phase   = PH_REST;
    sh_verdict = V_MALFORMED;
  endtask

  // One ordinary byte of the status line
  task automatic status_line_byte(logic [7:0] c);
    int unsigned acc;
    case (sh_phase)
      PH_PREFIX: begin
        if (sh_tag_idx < TAG_LEN && c == HTTP_TAG[39 - 8 * sh_tag_idx -: 8]) begin
          sh_tag_idx = sh_tag_idx + 3'd1;
          if (sh_tag_idx == TAG_LEN) sh_phase = PH_VER_NONE;
        end else begin
          mark_malformed();
        end
      end
      PH_VER_NONE: begin
        if (is_digit(c)) sh_phase = PH_VER;
        else if (c == CH_DOT && !sh_dot) sh_dot = 1'b1;
        else if (!(is_blank(c) && !sh_dot)) mark_malformed();
      end
      PH_VER: begin
        if (is_digit(c)) begin
        end else if (c == CH_DOT && !sh_dot) begin
          sh_dot = 1'b1;
        end else if (is_blank(c)) begin
          sh_phase = PH_BLANKS;
        end else begin
          mark_malformed();
        end
      end
      PH_BLANKS: begin
        if (is_digit(c)) begin
          sh_status = 16'(c - CH_ZERO);
          sh_phase  = PH_STATUS;
        end else if (!is_blank(c)) begin
          mark_malformed();
        end
      end
      PH_STATUS: begin
        if (is_digit(c)) begin
          acc = sh_status * 10 + (c - CH_ZERO);
          if (acc > STATUS_MAX) acc = STATUS_MAX;
          sh_status = 16'(acc);
        end else begin
          sh_phase = PH_REST;
        end
      end
      default: begin
      end
    endcase
  endtask

  // CRLF closing the status line
  task automatic status_line_done();
    bit good;
    good = (sh_phase == PH_STATUS) || (sh_phase == PH_REST && sh_verdict != V_MALFORMED);
    if (!good) begin
      sh_phase   = PH_AFTER;
      sh_verdict = V_MALFORMED;
    end else if (sh_status == 16'd200) begin
      sh_phase      = PH_HEADERS;
      sh_line_empty = 1'b1;
      sh_verdict    = V_NO_END;
    end else begin
      sh_phase   = PH_AFTER;
      sh_verdict = (sh_status == 16'd301 || sh_status == 16'd302) ? V_REDIRECT : V_OTHER;
    end
  endtask

  // Work out the results caused by one accepted byte
  task automatic predict_byte(logic [7:0] c, logic last);
    result_t r;
    bit      known;
    if (sh_phase <= PH_REST) begin
      if (sh_cr && c == CH_LF) begin
        sh_cr = 1'b0;
        status_line_done();
      end else begin
        if (sh_cr) status_line_byte(CH_CR);
        if (c == CH_CR) begin
          sh_cr = 1'b1;
        end else begin
          sh_cr = 1'b0;
          status_line_byte(c);
        end
      end
    end else if (sh_phase == PH_HEADERS) begin
      if (sh_cr && c == CH_LF) begin
        sh_cr = 1'b0;
        if (sh_line_empty) begin
          sh_phase   = PH_AFTER;
          sh_verdict = V_OK;
        end else begin
          sh_line_empty = 1'b1;
        end
      end else if (c == CH_CR) begin
        if (sh_cr) sh_line_empty = 1'b0;
        sh_cr = 1'b1;
      end else begin
        sh_cr         = 1'b0;
        sh_line_empty = 1'b0;
      end
    end else if (sh_verdict == V_OK) begin
      r.out_kind     = KIND_BODY;
      r.body_byte    = c;
      r.verdict      = V_OK;
      r.status_value = '0;
      r.is_last      = 1'b0;
      pending_results.push_back(r);
    end

    if (last) begin
      known = (sh_phase == PH_HEADERS) || (sh_phase == PH_AFTER && sh_verdict <= V_OTHER);
      r.out_kind     = KIND_VERDICT;
      r.body_byte    = '0;
      r.verdict      = (sh_phase == PH_AFTER) ? sh_verdict : V_NO_END;
      r.status_value = known ? sh_status : 16'd0;
      r.is_last      = 1'b1;
      pending_results.push_back(r);
      parser_clear();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Byte source
  // ---------------------------------------------------------------------------
  task automatic send_byte(logic [7:0] b, logic last);
    int unsigned gap;
    if (src_idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 17);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.rx_byte      <= b;
    in_if.end_of_reply <= last;
    do @(posedge clk_i); while (!in_if.ready);
    predict_byte(b, last);
    bytes_sent++;
    if (last) replies_sent++;
  endtask

  task automatic push_str(string s);
    for (int i = 0; i < s.len(); i++) reply_buf.push_back(s[i]);
  endtask

  // Send the first n buffered bytes, the last one closing the reply
  task automatic send_buf(int unsigned n);
    for (int unsigned i = 0; i < n; i++) send_byte(reply_buf[i], i == n - 1);
    reply_buf.delete();
  endtask

  task automatic send_reply(string s);
    push_str(s);
    send_buf(reply_buf.size());
  endtask

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------
  task automatic cmp_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  task automatic check_result();
    result_t want;
    results_seen++;
    if (pending_results.size() == 0) begin
      errors++;
      $display("%0t: extra result: expected none, actual k=%0d b=%0d v=%0d s=%0d l=%0d",
               $time, out_if.out_kind, out_if.body_byte, out_if.verdict,
               out_if.status_value, out_if.is_last);
      return;
    end
    want = pending_results.pop_front();
    cmp_field("out_kind", want.out_kind, out_if.out_kind);
    cmp_field("body_byte", want.body_byte, out_if.body_byte);
    cmp_field("verdict", want.verdict, out_if.verdict);
    cmp_field("status_value", want.status_value, out_if.status_value);
    cmp_field("is_last", want.is_last, out_if.is_last);
  endtask

  // Result sink with random stall bursts
  initial begin
    int unsigned stall;
    stall = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid && out_if.ready) check_result();
      if (stall > 0) begin
        stall--;
        out_if.ready <= 1'b0;
      end else if (snk_idle_en && $urandom_range(0, 6) == 0) begin
        stall = $urandom_range(0, 16);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Ok, redirect, other and saturated status values
  task automatic test_status_codes();
    push_str("HTTP/1.1 200 OK\r\nA: b\r\n\r\n");
    reply_buf.push_back(8'h00);
    reply_buf.push_back(8'hFF);
    send_buf(reply_buf.size());
    send_reply("HTTP/1.0 301\r\n");
    send_reply("HTTP/2 302 Found\r\nx");
    send_reply("HTTP/1.1 404 NF\r\n");
    send_reply("HTTP/1.1 99999\r\n");
    send_reply("HTTP/ \t.5\t 0200\r\n\r\nZ");
    send_reply("HTTP/1.1 200\r\n\r\n");
  endtask

  // Broken status lines
  task automatic test_malformed_lines();
    send_reply("HTTX/1.1 200\r\n");
    send_reply("HTTP/1.1.1 200\r\n");
    send_reply("HTTP/..1 200\r\n");
    send_reply("HTTP/1.1 \r\n");
    send_reply("HTTP/1\r1 200\r\n");
    send_byte("H", 1'b1);
  endtask

  // Missing line ends and lone CRs
  task automatic test_line_ends();
    send_reply("HTTP/1.1 200");
    send_reply("HTTP/1.1 200\r\nA: b\r\n");
    send_reply("HTTP/1.1 200\r\nA\r\r\n\r\nQ");
    send_reply("HTTP/1.1 200\r\r\n\r\nB");
    send_reply("HTTP/1.1 200\r\n\r\r\n\r\nC");
  endtask

  // Mostly well formed replies with random content, some corrupted
  task automatic build_reply();
    int unsigned status;
    int unsigned pick;
    int unsigned n;
    n = $urandom_range(1, 2);
    push_str("HTTP/");
    repeat (n) reply_buf.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
    if ($urandom_range(0, 3) != 0) begin
      reply_buf.push_back(CH_DOT);
      repeat ($urandom_range(1, 2)) reply_buf.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
    end
    repeat ($urandom_range(1, 2)) reply_buf.push_back($urandom_range(0, 1) ? CH_SP : CH_TAB);
    pick = $urandom_range(0, 9);
    if (pick < 5) status = 200;
    else if (pick == 5) status = 301;
    else if (pick == 6) status = 302;
    else if (pick == 7) status = $urandom_range(100, 599);
    else if (pick == 8) status = $urandom_range(0, 999999);
    else status = $urandom_range(0, 65535);
    push_str($sformatf("%0d", status));
    if ($urandom_range(0, 1)) push_str(" OK");
    push_str("\r\n");
    // header lines, occasionally with a lone CR inside
    repeat ($urandom_range(0, 2)) begin
      repeat ($urandom_range(1, 5)) reply_buf.push_back(8'($urandom_range(8'h20, 8'h7E)));
      if ($urandom_range(0, 5) == 0) reply_buf.push_back(CH_CR);
      push_str("\r\n");
    end
    push_str("\r\n");
    repeat ($urandom_range(0, 12)) reply_buf.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic test_random_replies(int unsigned byte_goal);
    int unsigned mode;
    while (bytes_sent < byte_goal) begin
      build_reply();
      mode = $urandom_range(0, 9);
      case (mode)
        0: begin
          reply_buf[$urandom_range(0, reply_buf.size() - 1)] = 8'($urandom_range(0, 255));
          send_buf(reply_buf.size());
        end
        1: send_buf($urandom_range(1, reply_buf.size()));
        2: begin
          reply_buf.delete();
          repeat ($urandom_range(1, 12)) reply_buf.push_back(8'($urandom_range(0, 255)));
          send_buf(reply_buf.size());
        end
        default: send_buf(reply_buf.size());
      endcase
    end
  endtask

  // Full rate on both sides
  task automatic test_back_to_back();
    src_idle_en = 1'b0;
    snk_idle_en = 1'b0;
    test_random_replies(bytes_sent + 150);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    errors       = 0;
    bytes_sent   = 0;
    replies_sent = 0;
    results_seen = 0;
    src_idle_en  = 1'b1;
    snk_idle_en  = 1'b1;
    parser_clear();
    rst_ni             <= 1'b0;
    in_if.valid        <= 1'b0;
    in_if.rx_byte      <= '0;
    in_if.end_of_reply <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_status_codes();
    test_malformed_lines();
    test_line_ends();
    test_random_replies(bytes_sent + 460);
    test_back_to_back();

    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Sent %0d bytes in %0d replies, checked %0d results, %0d mismatches",
             bytes_sent, replies_sent, results_seen, errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Timeout with %0d results outstanding", pending_results.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule

/* filelist.f */
sv/hrhs_pkg.sv
sv/hrhs_if.sv
sv/hrhs_parser.sv
sv/hrhs_out_queue.sv
sv/http_reply_header_stripper.sv
verif/tb_top.sv
